FILE: hdl/ast_pkg.sv
package ast_pkg;

    // Character codes recognised by the scanner
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Saturation limit of a token length
    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        KIND_NEWLINE = 3'd0,
        KIND_COLON   = 3'd1,
        KIND_DOT     = 3'd2,
        KIND_COMMA   = 3'd3,
        KIND_IDENT   = 3'd4,
        KIND_NUMBER  = 3'd5,
        KIND_ERROR   = 3'd6
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_IDENT   = 2'd2,
        MODE_NUMBER  = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        token_kind_t token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [31:0] number_value;
        logic        last_of_run;
    } out_item_t;

    // One token as built by the front end
    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [31:0] value;
    } tok_t;

    // Tokens caused by one byte: tok0, and tok1 when two is set
    typedef struct packed {
        tok_t tok0;
        tok_t tok1;
        logic two;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

endpackage

FILE: hdl/ast_front.sv
module ast_front #(
    parameter int POSITION_BITS = 16,
    parameter int VALUE_BITS    = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ast_pkg::in_item_t in_item,
    input  logic              q_full,
    output logic              q_push,
    output ast_pkg::entry_t   q_data
);
    import ast_pkg::*;

    scan_mode_t               mode_reg,  mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [VALUE_BITS-1:0]    acc_reg,   acc_next;
    logic [15:0]              len_reg,   len_next;
    logic                     halt_reg,  halt_next;

    logic                     accept;
    logic [7:0]               c;
    logic                     last;
    logic [VALUE_BITS+3:0]    sum_wide;
    logic [VALUE_BITS-1:0]    acc_ext;
    logic [POSITION_BITS+15:0] pos_wide;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign c        = in_item.text_byte;
    assign last     = in_item.end_of_text;
    assign pos_wide = {16'b0, pos_reg};

    // acc * 10 + digit, saturating
    assign sum_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + (VALUE_BITS+4)'(c[3:0]);
    assign acc_ext  = (|sum_wide[VALUE_BITS+3:VALUE_BITS]) ? '1
                    : sum_wide[VALUE_BITS-1:0];

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            acc_reg   <= '0;
            len_reg   <= '0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            halt_reg  <= halt_next;
        end
    end

    // Scan step: next state and up to two tokens
    always_comb
    begin
        logic [POSITION_BITS+15:0] s_wide;
        logic [VALUE_BITS+31:0]    v_wide;
        logic                      consumed;
        logic [1:0]                n;
        tok_t                      toks [2];

        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        halt_next  = halt_reg;
        consumed   = 1'b0;
        n          = 2'd0;
        toks[0]    = '0;
        toks[1]    = '0;
        s_wide     = '0;
        v_wide     = '0;

        if (accept && halt_reg)
        begin
            // halted: drop bytes until the end of text
            if (last)
            begin
                mode_next  = MODE_IDLE;
                start_next = '0;
                pos_next   = '0;
                acc_next   = '0;
                len_next   = '0;
                halt_next  = 1'b0;
            end
        end
        else if (accept)
        begin
            // open run or comment
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (c == CH_NL)
                        mode_next = MODE_IDLE;
                    consumed = 1'b1;
                end
                MODE_IDENT:
                begin
                    if (is_letter(c) || is_digit(c))
                    begin
                        if (len_reg != LENGTH_MAX)
                            len_next = len_reg + 16'd1;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        s_wide = {16'b0, start_reg};
                        toks[n[0]] = '{KIND_IDENT, s_wide[15:0], len_reg, 32'd0};
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        if (len_reg != LENGTH_MAX)
                            len_next = len_reg + 16'd1;
                        acc_next = acc_ext;
                        consumed = 1'b1;
                    end
                    else
                    begin
                        s_wide = {16'b0, start_reg};
                        v_wide = {32'b0, acc_reg};
                        toks[n[0]] = '{KIND_NUMBER, s_wide[15:0], len_reg,
                                       v_wide[31:0]};
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            // byte outside any run
            if (!consumed)
            begin
                case (c)
                    CH_SPACE:
                    begin
                    end
                    CH_HASH:
                        mode_next = MODE_COMMENT;
                    CH_NL:
                    begin
                        toks[n[0]] = '{KIND_NEWLINE, pos_wide[15:0], 16'd1, 32'd0};
                        n = n + 2'd1;
                    end
                    CH_COLON:
                    begin
                        toks[n[0]] = '{KIND_COLON, pos_wide[15:0], 16'd1, 32'd0};
                        n = n + 2'd1;
                    end
                    CH_DOT:
                    begin
                        toks[n[0]] = '{KIND_DOT, pos_wide[15:0], 16'd1, 32'd0};
                        n = n + 2'd1;
                    end
                    CH_COMMA:
                    begin
                        toks[n[0]] = '{KIND_COMMA, pos_wide[15:0], 16'd1, 32'd0};
                        n = n + 2'd1;
                    end
                    default:
                    begin
                        if (is_letter(c))
                        begin
                            mode_next  = MODE_IDENT;
                            start_next = pos_reg;
                            len_next   = 16'd1;
                            acc_next   = '0;
                        end
                        else if (is_digit(c))
                        begin
                            mode_next  = MODE_NUMBER;
                            start_next = pos_reg;
                            len_next   = 16'd1;
                            acc_next   = VALUE_BITS'(c[3:0]);
                        end
                        else
                        begin
                            toks[n[0]] = '{KIND_ERROR, pos_wide[15:0], 16'd1, 32'd0};
                            n = n + 2'd1;
                            halt_next = 1'b1;
                        end
                    end
                endcase
            end

            // end of text closes any open run and restarts
            if (last)
            begin
                if (!halt_next)
                begin
                    s_wide = {16'b0, start_next};
                    v_wide = {32'b0, acc_next};
                    if (mode_next == MODE_IDENT)
                    begin
                        toks[n[0]] = '{KIND_IDENT, s_wide[15:0], len_next, 32'd0};
                        n = n + 2'd1;
                    end
                    else if (mode_next == MODE_NUMBER)
                    begin
                        toks[n[0]] = '{KIND_NUMBER, s_wide[15:0], len_next,
                                       v_wide[31:0]};
                        n = n + 2'd1;
                    end
                end
                mode_next  = MODE_IDLE;
                start_next = '0;
                pos_next   = '0;
                acc_next   = '0;
                len_next   = '0;
                halt_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end

        q_push      = accept && (n != 2'd0);
        q_data.tok0 = toks[0];
        q_data.tok1 = toks[1];
        q_data.two  = (n == 2'd2);
    end

endmodule

FILE: hdl/ast_queue.sv
module ast_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ast_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output ast_pkg::entry_t pop_data,
    output logic            empty
);
    import ast_pkg::*;

    entry_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_BITS+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_BITS+1)'(1);
        end
    end

endmodule

FILE: hdl/ast_back.sv
module ast_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ast_pkg::entry_t    q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ast_pkg::out_item_t out_item
);
    import ast_pkg::*;

    entry_t    cur_reg;
    logic      cur_valid_reg;
    logic      sel_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic      out_load;
    logic      cur_last;
    logic      cur_done;
    tok_t      cur_tok;

    assign out_load = cur_valid_reg && (!out_valid_reg || out_ready);
    assign cur_last = !cur_reg.two || sel_reg;
    assign cur_done = out_load && cur_last;
    assign cur_tok  = sel_reg ? cur_reg.tok1 : cur_reg.tok0;
    assign q_pop    = !q_empty && (!cur_valid_reg || cur_done);

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Entry being unpacked, one token per cycle while the receiver takes them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            sel_reg       <= 1'b0;
        end
        else if (cur_done)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.token_kind   <= cur_tok.kind;
            out_reg.token_start  <= cur_tok.start;
            out_reg.token_length <= cur_tok.length;
            out_reg.number_value <= cur_tok.value;
            out_reg.last_of_run  <= cur_last;
        end
    end

endmodule

FILE: hdl/assembler_source_tokenizer.sv
// A token goes via the four-entry queue and an entry register to the output register.
// Throughput: one byte per cycle while the queue has room; a byte causing two tokens
// sends them in turn through the single-token output register; the queue absorbs bursts.
// Input ready drops only while the token queue is full.
// Reset (rst_n, asynchronous, active low) clears the scan state, the queue and the
// output valid; the scan state also returns to reset after every end-of-text byte.
module assembler_source_tokenizer #(
    parameter int POSITION_BITS = 16,
    parameter int VALUE_BITS    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ast_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output ast_pkg::out_item_t out_item
);
    import ast_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    entry_t q_wdata;
    entry_t q_rdata;

    // Byte classification and run tracking
    ast_front #(
        .POSITION_BITS (POSITION_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    // Token queue
    ast_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // Token output
    ast_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: hdl/ast_checker.sv
module ast_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input ast_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_ready,
    input ast_pkg::out_item_t out_item
);
    import ast_pkg::*;

    // Offered byte holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed while waiting");

    // Stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output token changed while stalled");

    // Only number tokens carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind != KIND_NUMBER) |-> out_item.number_value == 32'd0)
        else $error("non-number token with a value");

    // Single-byte tokens have length one
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind == KIND_NEWLINE || out_item.token_kind == KIND_COLON
        || out_item.token_kind == KIND_DOT || out_item.token_kind == KIND_COMMA
        || out_item.token_kind == KIND_ERROR) |-> out_item.token_length == 16'd1)
        else $error("single-byte token with wrong length");

    // Runs are never empty
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.token_kind == KIND_IDENT || out_item.token_kind == KIND_NUMBER)
        |-> out_item.token_length != 16'd0)
        else $error("run token of zero length");

endmodule

bind assembler_source_tokenizer ast_checker u_checker (.*);

FILE: test/tb_assembler_source_tokenizer.sv
`timescale 1ns / 1ps

module tb_assembler_source_tokenizer;

    import ast_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1620;
    localparam int HOLD_CYCLES  = 200;
    localparam int BURST_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 50;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // Scanner copy used to work out the tokens of each byte
    scan_mode_t  sc_mode;
    logic [15:0] sc_start;
    logic [15:0] sc_pos;
    logic [15:0] sc_len;
    logic [31:0] sc_acc;
    logic        sc_halt;
    out_item_t   byte_tok [2];
    int          byte_ntok;

    out_item_t   tok_q [$];
    logic [7:0]  text_buf [$];
    stim_row_t   dir_tab [$];
    int          mismatches = 0;
    int          tok_seen = 0;
    int          sent_items = 0;
    int          idle_cycles = 0;
    bit          gaps_on;
    bit          hold_req;

    assembler_source_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit letter_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic out_item_t make_tok(input token_kind_t k, input logic [15:0] s,
                                           input logic [15:0] l, input logic [31:0] v,
                                           input logic last);
        out_item_t t;
        t.token_kind   = k;
        t.token_start  = s;
        t.token_length = l;
        t.number_value = v;
        t.last_of_run  = last;
        return t;
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] b, input logic eot);
        stim_row_t r;
        r.item.text_byte   = b;
        r.item.end_of_text = eot;
        r.typed            = 1'b0;
        r.want             = '0;
        return r;
    endfunction

    // Single-byte token known at a glance: length one, no value, last of its byte
    function automatic stim_row_t typed_row(input logic [7:0] b, input logic eot,
                                            input token_kind_t k, input logic [15:0] s);
        stim_row_t r;
        r       = plain_row(b, eot);
        r.typed = 1'b1;
        r.want  = make_tok(k, s, 16'd1, 32'd0, 1'b1);
        return r;
    endfunction

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Queue appends
    task automatic tok_add(input out_item_t t);
        tok_q.insert(tok_q.size(), t);
    endtask

    task automatic text_add(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic row_add(input stim_row_t r);
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic scan_clear();
        sc_mode  = MODE_IDLE;
        sc_start = '0;
        sc_pos   = '0;
        sc_len   = '0;
        sc_acc   = '0;
        sc_halt  = 1'b0;
    endtask

    task automatic tok_emit(input token_kind_t k, input logic [15:0] s,
                            input logic [15:0] l, input logic [31:0] v);
        byte_tok[byte_ntok] = make_tok(k, s, l, v, 1'b0);
        byte_ntok++;
    endtask

    task automatic run_close();
        if (sc_mode == MODE_IDENT)
            tok_emit(KIND_IDENT, sc_start, sc_len, 32'd0);
        else if (sc_mode == MODE_NUMBER)
            tok_emit(KIND_NUMBER, sc_start, sc_len, sc_acc);
        sc_mode = MODE_IDLE;
    endtask

    task automatic len_bump();
        if (sc_len != LENGTH_MAX)
            sc_len++;
    endtask

    // Saturating decimal accumulate; a digit's low nibble is its value
    task automatic acc_digit(input logic [7:0] c);
        logic [31:0] d;
        d = {28'd0, c[3:0]};
        if (sc_acc > (32'hFFFF_FFFF - d) / 32'd10)
            sc_acc = 32'hFFFF_FFFF;
        else
            sc_acc = sc_acc * 32'd10 + d;
    endtask

    // Tokens caused by one byte go to byte_tok[0 .. byte_ntok-1]
    task automatic scan_byte(input in_item_t it);
        logic [7:0]  c;
        logic [15:0] pos;
        bit          taken;
        c         = it.text_byte;
        pos       = sc_pos;
        taken     = 0;
        byte_ntok = 0;
        if (sc_halt)
        begin
            if (it.end_of_text)
                scan_clear();
            return;
        end

        // open run or comment first
        case (sc_mode)
            MODE_COMMENT:
            begin
                if (c == CH_NL)
                    sc_mode = MODE_IDLE;
                taken = 1;
            end
            MODE_IDENT:
            begin
                if (letter_byte(c) || digit_byte(c))
                begin
                    len_bump();
                    taken = 1;
                end
                else
                    run_close();
            end
            MODE_NUMBER:
            begin
                if (digit_byte(c))
                begin
                    len_bump();
                    acc_digit(c);
                    taken = 1;
                end
                else
                    run_close();
            end
            default: ;
        endcase

        // byte seen with no run open
        if (!taken)
        begin
            if (c == CH_SPACE)
                taken = 1;
            else if (c == CH_HASH)
                sc_mode = MODE_COMMENT;
            else if (c == CH_NL)
                tok_emit(KIND_NEWLINE, pos, 16'd1, 32'd0);
            else if (c == CH_COLON)
                tok_emit(KIND_COLON, pos, 16'd1, 32'd0);
            else if (c == CH_DOT)
                tok_emit(KIND_DOT, pos, 16'd1, 32'd0);
            else if (c == CH_COMMA)
                tok_emit(KIND_COMMA, pos, 16'd1, 32'd0);
            else if (letter_byte(c))
            begin
                sc_mode  = MODE_IDENT;
                sc_start = pos;
                sc_len   = 16'd1;
                sc_acc   = '0;
            end
            else if (digit_byte(c))
            begin
                sc_mode  = MODE_NUMBER;
                sc_start = pos;
                sc_len   = 16'd1;
                sc_acc   = '0;
                acc_digit(c);
            end
            else
            begin
                tok_emit(KIND_ERROR, pos, 16'd1, 32'd0);
                sc_halt = 1'b1;
            end
        end

        if (it.end_of_text)
        begin
            if (!sc_halt)
                run_close();
            scan_clear();
        end
        else
            sc_pos = pos + 16'd1;
    endtask

    // Offer one item after a random gap, then record the tokens it causes
    task automatic send_byte(input stim_row_t r);
        int        gap;
        int        i;
        out_item_t t;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= r.item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
        scan_byte(r.item);
        if (r.typed)
            tok_add(r.want);
        else
            for (i = 0; i < byte_ntok; i++)
            begin
                t             = byte_tok[i];
                t.last_of_run = (i == byte_ntok - 1);
                tok_add(t);
            end
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(plain_row(text_buf[i], i == text_buf.size() - 1));
    endtask

    // Mostly well-formed source lines; now and then a text of raw noise
    task automatic build_text();
        int lex;
        int len;
        int pick;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 16);
            repeat (len) text_add(8'($urandom_range(0, 255)));
            return;
        end
        lex = $urandom_range(1, 24);
        repeat (lex)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                text_add(rand_letter());
                len = $urandom_range(0, 6);
                repeat (len)
                    text_add(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
            end
            else if (pick < 45)
            begin
                // a few long numbers to hit saturation
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                  : $urandom_range(1, 4);
                repeat (len) text_add(rand_digit());
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 3))
                    0:       text_add(CH_COLON);
                    1:       text_add(CH_DOT);
                    2:       text_add(CH_COMMA);
                    default: text_add(CH_NL);
                endcase
            end
            else if (pick < 84)
            begin
                len = $urandom_range(1, 3);
                repeat (len) text_add(CH_SPACE);
            end
            else if (pick < 96)
            begin
                text_add(CH_HASH);
                len = $urandom_range(0, 6);
                repeat (len) text_add(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0)
                    text_add(CH_NL);
            end
            else if (pick < 98)
                text_add(8'($urandom_range(0, 255)));
            else
                text_add(8'($urandom_range(128, 255)));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: token %0d %s: got %0h, expected %0h",
                     $time, tok_seen, what, got, want);
        mismatches++;
    endtask

    // Result checker: each accepted token against the oldest expected one
    always @(posedge clk)
    begin : token_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tok_q.size() == 0)
                report_mismatch("arrived with none expected", out_item.token_kind, 0);
            else
            begin
                want = tok_q.pop_front();
                if (out_item.token_kind !== want.token_kind)
                    report_mismatch("kind", out_item.token_kind, want.token_kind);
                if (out_item.token_start !== want.token_start)
                    report_mismatch("start", out_item.token_start, want.token_start);
                if (out_item.token_length !== want.token_length)
                    report_mismatch("length", out_item.token_length, want.token_length);
                if (out_item.number_value !== want.number_value)
                    report_mismatch("value", out_item.number_value, want.number_value);
                if (out_item.last_of_run !== want.last_of_run)
                    report_mismatch("last", out_item.last_of_run, want.last_of_run);
            end
            tok_seen++;
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : token_sink
        int stall;
        out_ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 7) : 0;
            if (hold_req)
            begin
                hold_req = 0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Sender: directed table, back-pressure burst, random texts
    initial
    begin : byte_source
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        gaps_on  = 1;
        hold_req = 0;
        scan_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // punctuation, space, comment, number closed by a letter, ident closed by colon
        row_add(typed_row(CH_NL,    1'b0, KIND_NEWLINE, 16'd0));
        row_add(typed_row(CH_COLON, 1'b0, KIND_COLON,   16'd1));
        row_add(typed_row(CH_DOT,   1'b0, KIND_DOT,     16'd2));
        row_add(typed_row(CH_COMMA, 1'b0, KIND_COMMA,   16'd3));
        row_add(plain_row(CH_SPACE, 1'b0));
        row_add(plain_row(CH_HASH,  1'b0));
        row_add(plain_row("x",      1'b0));
        row_add(plain_row(CH_NL,    1'b0));
        row_add(plain_row("1",      1'b0));
        row_add(plain_row("2",      1'b0));
        row_add(plain_row("a",      1'b0));
        row_add(plain_row("Z",      1'b0));
        row_add(plain_row("9",      1'b0));
        row_add(plain_row(CH_COLON, 1'b0));
        row_add(plain_row("z",      1'b1));
        // number closed by the last byte
        row_add(plain_row("0",      1'b0));
        row_add(plain_row("9",      1'b1));
        // control byte: error, then the rest is ignored up to the last byte
        row_add(typed_row(8'h00,    1'b0, KIND_ERROR, 16'd0));
        row_add(plain_row("5",      1'b0));
        row_add(plain_row(CH_NL,    1'b1));
        // top byte value on the last byte
        row_add(typed_row(8'hFF,    1'b1, KIND_ERROR, 16'd0));
        // unterminated comment at the end
        row_add(plain_row(CH_HASH,  1'b0));
        row_add(plain_row("k",      1'b1));
        // one-byte texts
        row_add(plain_row("7",      1'b1));
        row_add(plain_row(CH_SPACE, 1'b1));
        for (i = 0; i < dir_tab.size(); i++)
            send_byte(dir_tab[i]);

        // receiver holds off while a run of punctuation fills the block
        gaps_on  = 0;
        hold_req = 1;
        for (i = 0; i < BURST_ITEMS; i++)
            send_byte(plain_row((i % 2 == 0) ? CH_COMMA : CH_COLON, i == BURST_ITEMS - 1));
        in_valid <= 1'b0;
        while (tok_q.size() != 0) @(posedge clk);

        // random texts, some stretches without idling
        while (sent_items < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            build_text();
            send_text();
        end

        in_valid <= 1'b0;
        while (tok_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
